// ===== rtl/assert_macros.svh =====
// Assertion macros included by the timed_button_auto_release RTL file.
// Each macro checks a property on the rising edge of clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication that starts in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication whose consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tbar_pkg.sv =====
// ----------------------------------------------------------------------------
// tbar_pkg
// Types and constants of the timed button auto-release block.
// ----------------------------------------------------------------------------
package tbar_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int BTN_W      = 17;
    localparam int TIME_W     = 32;
    localparam int STICK_W    = 16;

    localparam logic [STICK_W-1:0] STICK_CENTRE = 16'h0800;

    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_STICK   = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    // Command from the control path to the slot pool
    typedef struct packed {
        logic               alloc;
        logic               release_all;
        logic               tick;
        logic               is_stick;
        logic               left;
        logic [TIME_W-1:0]  expiry;
        logic [BTN_W-1:0]   owned;
        logic [TIME_W-1:0]  now;
    } slot_cmd_t;

    // Status from the slot pool back to the control path
    typedef struct packed {
        logic               free_found;
        logic               slots_busy;
        logic               any_expired;
        logic [BTN_W-1:0]   expired_buttons;
        logic               centre_left;
        logic               centre_right;
    } slot_stat_t;

endpackage

// ===== rtl/tbar_slots.sv =====
// ----------------------------------------------------------------------------
// tbar_slots
// Pool of timed-action slots: free-slot search, allocation, expiry and release-all.
// ----------------------------------------------------------------------------
module tbar_slots (
    input  logic                clk,
    input  logic                rst_n,
    input  tbar_pkg::slot_cmd_t cmd,
    output tbar_pkg::slot_stat_t stat
);
    import tbar_pkg::*;

    logic [SLOT_COUNT-1:0] active_reg;
    logic [SLOT_COUNT-1:0] active_next;
    logic [SLOT_COUNT-1:0] is_stick_reg;
    logic [SLOT_COUNT-1:0] left_reg;
    logic [TIME_W-1:0]     expiry_reg [SLOT_COUNT];
    logic [BTN_W-1:0]      owned_reg  [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] free_onehot;
    logic [SLOT_COUNT-1:0] expired;
    logic                  do_alloc;

    // Pick the lowest free slot
    assign free_onehot = ~active_reg & (active_reg + SLOT_COUNT'(1));
    assign do_alloc    = cmd.alloc && (|(~active_reg));

    // Compare every active slot against the current time
    always_comb
    begin
        stat.expired_buttons = '0;
        stat.centre_left     = 1'b0;
        stat.centre_right    = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            expired[i] = cmd.tick && active_reg[i] && (cmd.now >= expiry_reg[i]);
            if (expired[i] && !is_stick_reg[i])
            begin
                stat.expired_buttons = stat.expired_buttons | owned_reg[i];
            end
            if (expired[i] && is_stick_reg[i] && left_reg[i])
            begin
                stat.centre_left = 1'b1;
            end
            if (expired[i] && is_stick_reg[i] && !left_reg[i])
            begin
                stat.centre_right = 1'b1;
            end
        end
        stat.free_found  = |(~active_reg);
        stat.slots_busy  = |active_reg;
        stat.any_expired = |expired;
    end

    // Advance the active bits
    always_comb
    begin
        if (cmd.release_all)
        begin
            active_next = '0;
        end
        else if (cmd.tick)
        begin
            active_next = active_reg & ~expired;
        end
        else if (do_alloc)
        begin
            active_next = active_reg | free_onehot;
        end
        else
        begin
            active_next = active_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Record the slot contents on allocation
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (do_alloc && free_onehot[i])
            begin
                is_stick_reg[i] <= cmd.is_stick;
                left_reg[i]     <= cmd.left;
                expiry_reg[i]   <= cmd.expiry;
                owned_reg[i]    <= cmd.owned;
            end
        end
    end

endmodule

// ===== rtl/timed_button_auto_release.sv =====
// ----------------------------------------------------------------------------
// timed_button_auto_release
// Controller state with timed button presses and stick moves that release
// themselves when their slot expires.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: press,
//   release, stick move or tick, with the time and fields it needs.
//   Output channel (out_valid / out_stall) returns one result word per
//   command: held buttons, both stick positions, push report, accepted flag
//   and busy flag, all as they stand after the command.
//   An accepted word lands in an input register; from there it updates the
//   state and shows its result once the result side is free.
//   Throughput is one word per cycle while the receiver does not stall:
//   all slots are searched and compared against the time in parallel
//   within the single update stage.
//   When the receiver stalls, the result holds and the state does not move;
//   one more word may wait in the input register, then in_stall rises.
//   Reset frees all slots, clears the buttons, centres both sticks at 0x800
//   and clears the change flag; both channels come up empty.
// ----------------------------------------------------------------------------
module timed_button_auto_release (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic [tbar_pkg::TIME_W-1:0]       current_time,
    input  logic [tbar_pkg::BTN_W-1:0]        button_mask,
    input  logic                              release_all,
    input  logic                              stick_select,
    input  logic signed [tbar_pkg::STICK_W-1:0] stick_x,
    input  logic signed [tbar_pkg::STICK_W-1:0] stick_y,
    input  logic [tbar_pkg::TIME_W-1:0]       duration_ticks,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tbar_pkg::BTN_W-1:0]        buttons,
    output logic [tbar_pkg::STICK_W-1:0]      left_stick_x,
    output logic [tbar_pkg::STICK_W-1:0]      left_stick_y,
    output logic [tbar_pkg::STICK_W-1:0]      right_stick_x,
    output logic [tbar_pkg::STICK_W-1:0]      right_stick_y,
    output logic                              push_report,
    output logic                              accepted,
    output logic                              busy_res
);
    import tbar_pkg::*;

    `include "assert_macros.svh"

    // Input register
    logic                 in_full_reg;
    op_t                  op_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [BTN_W-1:0]     mask_reg;
    logic                 all_reg;
    logic                 left_reg;
    logic [STICK_W-1:0]   sx_reg;
    logic [STICK_W-1:0]   sy_reg;
    logic [TIME_W-1:0]    dur_reg;

    // Controller state, which also serves as the result register
    logic [BTN_W-1:0]     held_reg,  held_next;
    logic [STICK_W-1:0]   lx_reg,    lx_next;
    logic [STICK_W-1:0]   ly_reg,    ly_next;
    logic [STICK_W-1:0]   rx_reg,    rx_next;
    logic [STICK_W-1:0]   ry_reg,    ry_next;
    logic                 changed_reg, changed_next;
    logic                 push_reg,  push_next;
    logic                 acc_reg,   acc_next;
    logic                 out_valid_reg;

    logic                 advance;
    logic                 in_take;
    slot_cmd_t            cmd;
    slot_stat_t           stat;

    // Move the held word into the update stage when the result side is free
    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // Hold the input word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= op_t'(operation);
            now_reg  <= current_time;
            mask_reg <= button_mask;
            all_reg  <= release_all;
            left_reg <= stick_select;
            sx_reg   <= stick_x;
            sy_reg   <= stick_y;
            dur_reg  <= duration_ticks;
        end
    end

    // Drive the slot pool
    always_comb
    begin
        cmd.alloc       = advance && ((op_reg == OP_PRESS) || (op_reg == OP_STICK));
        cmd.release_all = advance && (op_reg == OP_RELEASE) && all_reg;
        cmd.tick        = advance && (op_reg == OP_TICK);
        cmd.is_stick    = (op_reg == OP_STICK);
        cmd.left        = (op_reg == OP_STICK) && left_reg;
        cmd.expiry      = now_reg + dur_reg;
        cmd.owned       = (op_reg == OP_STICK) ? '0 : mask_reg;
        cmd.now         = now_reg;
    end

    tbar_slots u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Update the controller state for one command
    always_comb
    begin
        held_next    = held_reg;
        lx_next      = lx_reg;
        ly_next      = ly_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        changed_next = changed_reg;
        push_next    = 1'b0;
        acc_next     = 1'b1;
        unique case (op_reg)
            OP_PRESS:
            begin
                if (stat.free_found)
                begin
                    held_next    = held_reg | mask_reg;
                    changed_next = 1'b1;
                end
                else
                begin
                    acc_next = 1'b0;
                end
            end
            OP_STICK:
            begin
                if (stat.free_found)
                begin
                    if (left_reg)
                    begin
                        lx_next = sx_reg;
                        ly_next = sy_reg;
                    end
                    else
                    begin
                        rx_next = sx_reg;
                        ry_next = sy_reg;
                    end
                    changed_next = 1'b1;
                end
                else
                begin
                    acc_next = 1'b0;
                end
            end
            OP_RELEASE:
            begin
                if (all_reg)
                begin
                    held_next = '0;
                    lx_next   = STICK_CENTRE;
                    ly_next   = STICK_CENTRE;
                    rx_next   = STICK_CENTRE;
                    ry_next   = STICK_CENTRE;
                end
                else
                begin
                    held_next = held_reg & ~mask_reg;
                end
                changed_next = 1'b1;
            end
            OP_TICK:
            begin
                held_next = held_reg & ~stat.expired_buttons;
                if (stat.centre_left)
                begin
                    lx_next = STICK_CENTRE;
                    ly_next = STICK_CENTRE;
                end
                if (stat.centre_right)
                begin
                    rx_next = STICK_CENTRE;
                    ry_next = STICK_CENTRE;
                end
                push_next    = changed_reg || stat.any_expired;
                changed_next = 1'b0;
            end
            default:
            begin
                acc_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            lx_reg        <= STICK_CENTRE;
            ly_reg        <= STICK_CENTRE;
            rx_reg        <= STICK_CENTRE;
            ry_reg        <= STICK_CENTRE;
            changed_reg   <= 1'b0;
            push_reg      <= 1'b0;
            acc_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                held_reg    <= held_next;
                lx_reg      <= lx_next;
                ly_reg      <= ly_next;
                rx_reg      <= rx_next;
                ry_reg      <= ry_next;
                changed_reg <= changed_next;
                push_reg    <= push_next;
                acc_reg     <= acc_next;
            end
            // Drop the result once taken, raise it when a new one lands
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign buttons       = held_reg;
    assign left_stick_x  = lx_reg;
    assign left_stick_y  = ly_reg;
    assign right_stick_x = rx_reg;
    assign right_stick_y = ry_reg;
    assign push_report   = push_reg;
    assign accepted      = acc_reg;
    assign busy_res      = stat.slots_busy;

    // An empty input register never stalls the sender
    `ASSERT_SAME(a_empty_no_stall, !in_full_reg, !in_stall, "stall with empty input register")
    // Release-all leaves no slot active
    `ASSERT_NEXT(a_release_all_idle, cmd.release_all, !busy_res, "slot active after release-all")
    // A refused command means every slot was taken
    `ASSERT_SAME(a_refused_busy, out_valid && !accepted, busy_res, "refused with a free slot")

endmodule
